@@ hw/rtl/autopilot_motor_command_handler_top_defines.svh @@
// assertion macros shared by the motor command handler rtl
`ifndef AUTOPILOT_MOTOR_COMMAND_HANDLER_TOP_DEFINES_SVH
`define AUTOPILOT_MOTOR_COMMAND_HANDLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define APMCH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apmch check failed");

// next-cycle implication, checked out of reset
`define APMCH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apmch check failed");

`endif

@@ hw/rtl/apmch_pkg.sv @@
// types, codes and telemetry schedule of the motor command handler
package apmch_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // received command codes
  localparam logic [7:0] RX_RESET_OC    = 8'hE7;
  localparam logic [7:0] RX_DRIVE       = 8'hC7;
  localparam logic [7:0] RX_MAX_CURRENT = 8'h1E;
  localparam logic [7:0] RX_CTRL_TEMP   = 8'hA4;
  localparam logic [7:0] RX_MOTOR_TEMP  = 8'h5A;
  localparam logic [7:0] RX_RUDDER_MIN  = 8'h2B;
  localparam logic [7:0] RX_RUDDER_MAX  = 8'h4D;
  localparam logic [7:0] RX_SLEW        = 8'h71;
  localparam logic [7:0] RX_CLUTCH      = 8'h36;

  // telemetry codes
  localparam logic [7:0] TX_FLAGS      = 8'h8F;
  localparam logic [7:0] TX_CURRENT    = 8'h1C;
  localparam logic [7:0] TX_RUDDER     = 8'hA7;
  localparam logic [7:0] TX_VOLTAGE    = 8'hB3;
  localparam logic [7:0] TX_CTRL_TEMP  = 8'hF9;
  localparam logic [7:0] TX_MOTOR_TEMP = 8'h48;

  // status flag masks
  localparam logic [15:0] FL_SYNC        = 16'h0001;
  localparam logic [15:0] FL_OVERTEMP    = 16'h0002;
  localparam logic [15:0] FL_OVERCURRENT = 16'h0004;
  localparam logic [15:0] FL_ENGAGED     = 16'h0008;
  localparam logic [15:0] FL_PORT_PIN    = 16'h0020;
  localparam logic [15:0] FL_STBD_PIN    = 16'h0040;
  localparam logic [15:0] FL_BADVOLT     = 16'h0080;
  localparam logic [15:0] FL_MIN_RUDDER  = 16'h0100;
  localparam logic [15:0] FL_MAX_RUDDER  = 16'h0200;
  localparam logic [15:0] FL_CUR_RANGE   = 16'h0400;
  localparam logic [15:0] FL_REBOOTED    = 16'h8000;

  // limits
  localparam logic [15:0] CMD_MAX      = 16'd2000;
  localparam logic [10:0] CMD_STOP     = 11'd1000;
  localparam logic [15:0] CMD_STOP_V   = 16'd1000;
  localparam logic [12:0] CUR_CAP_LOW  = 13'd2000;
  localparam logic [12:0] CUR_CAP_HIGH = 13'd5000;
  localparam logic [13:0] TEMP_CAP     = 14'd10000;
  localparam logic [7:0]  SLEW_MAX     = 8'd250;
  localparam logic [7:0]  SLEW_MIN     = 8'd1;
  localparam logic [7:0]  PWM_MIN      = 8'd30;
  localparam logic [7:0]  PWM_HIGH     = 8'd250;
  localparam logic [7:0]  PWM_FULL     = 8'd255;
  localparam logic [7:0]  CLUTCH_RESET = 8'd192;

  // fixed telemetry readings
  localparam logic [15:0] RD_CURRENT    = 16'd1000;
  localparam logic [15:0] RD_RUDDER     = 16'd1000;
  localparam logic [15:0] RD_VOLTAGE    = 16'd1200;
  localparam logic [15:0] RD_CTRL_TEMP  = 16'd6600;
  localparam logic [15:0] RD_MOTOR_TEMP = 16'd4200;

  typedef struct packed {
    logic [6:0] fault_inputs;
    logic [7:0] byte_two;
    logic [7:0] byte_one;
    logic [7:0] rx_code;
  } item_t;

  typedef struct packed {
    logic [7:0]  clutch_level;
    logic [15:0] slew_limits;
    logic [15:0] rudder_high_stop;
    logic [15:0] rudder_low_stop;
    logic [13:0] motor_temp_ceiling;
    logic [13:0] ctrl_temp_ceiling;
    logic [12:0] current_ceiling;
    logic [7:0]  brake_level;
    logic [10:0] drive_command;
    logic [15:0] tx_value;
    logic [7:0]  tx_code;
    logic        tx_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic        valid;
    logic        is_flags;
    logic [7:0]  code;
    logic [15:0] value;
  } tlm_t;

  function automatic tlm_t tlm_lookup(input logic [SLOT_W-1:0] slot);
    tlm_t t;
    t = '0;
    case (slot)
      0, 10, 20, 30: begin
        t.valid = 1'b1; t.is_flags = 1'b1; t.code = TX_FLAGS;
      end
      1, 4, 7, 11, 14, 17, 21, 24, 27, 31, 34, 37, 40: begin
        t.valid = 1'b1; t.code = TX_CURRENT; t.value = RD_CURRENT;
      end
      2, 5, 8, 12, 15, 18, 22, 25, 28, 32, 35, 38, 41: begin
        t.valid = 1'b1; t.code = TX_RUDDER; t.value = RD_RUDDER;
      end
      3, 13, 23, 33: begin
        t.valid = 1'b1; t.code = TX_VOLTAGE; t.value = RD_VOLTAGE;
      end
      6: begin
        t.valid = 1'b1; t.code = TX_CTRL_TEMP; t.value = RD_CTRL_TEMP;
      end
      9: begin
        t.valid = 1'b1; t.code = TX_MOTOR_TEMP; t.value = RD_MOTOR_TEMP;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ hw/rtl/autopilot_motor_command_handler_top.sv @@
// top level of the autopilot motor command handler
// One received packet per request on the s_ stream (code byte, two payload bytes and the
// fault inputs) produces exactly one result on the m_ stream: the telemetry packet of the
// current schedule slot (or tx_valid low with zero code and value on an idle slot) plus the
// updated drive command and stored settings. The block takes one request every cycle unless
// the result side stalls. A request is held in an input register and decoded against the
// state in the following cycle; its result is loaded into the output register when that
// register is free or draining, which raises m_tvalid. The result register is the only
// thing that stalls the flow: while it holds an untaken result, the input register still
// accepts one more request. The low_current_range bit is written over the cfg channel,
// which is always ready.
`include "autopilot_motor_command_handler_top_defines.svh"

module autopilot_motor_command_handler_top (
  input  logic                               clk,
  input  logic                               rst,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,  // rx_code, byte_one, byte_two,
                                                       // fault_inputs, zero pad
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [apmch_pkg::TDATA_W-1:0]      m_tdata,  // tx_valid, tx_code, tx_value,
                                                       // drive_command, brake_level,
                                                       // current_ceiling, ctrl_temp_ceiling,
                                                       // motor_temp_ceiling,
                                                       // rudder_low_stop, rudder_high_stop,
                                                       // slew_limits, clutch_level,
                                                       // zero pad
  // configuration write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data  // low_current_range
);

  // input register
  logic              in_valid, in_valid_next;
  apmch_pkg::item_t  in_item;
  logic              in_load;

  // pipeline control
  logic              advance;
  logic              low_current_range;

  apmch_pkg::result_t core_result;
  apmch_pkg::result_t out_data;

  // move the held request into the result register when that one is free or draining
  assign advance   = in_valid & (~m_tvalid | m_tready);
  assign s_tready  = ~in_valid | advance;
  assign in_load   = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_next = in_load | (in_valid & ~advance);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item <= s_tdata[$bits(apmch_pkg::item_t)-1:0];
    end
  end

  // range register, reset to the low range
  always_ff @(posedge clk) begin
    if (rst) begin
      low_current_range <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      low_current_range <= cfg_data;
    end
  end

  apmch_core u_core (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .item              (in_item),
    .low_current_range (low_current_range),
    .result            (core_result)
  );

  apmch_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (core_result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .data     (out_data)
  );

  // struct is declared highest field first, so tx_valid lands in bit 0
  assign m_tdata = {{(apmch_pkg::TDATA_W - apmch_pkg::RESULT_W){1'b0}}, out_data};

  // a held request is never dropped while the result side stalls
  `APMCH_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !advance, in_valid)
  // a stalled result register never takes a new result
  `APMCH_ASSERT_IMP(a_no_overrun, clk, rst, m_tvalid && !m_tready, !advance)
  // with a request held and room downstream, the request moves on
  `APMCH_ASSERT_IMP(a_flow, clk, rst, in_valid && !m_tvalid, advance)

endmodule

@@ hw/rtl/apmch_core.sv @@
// state registers, command decode and telemetry schedule
`include "autopilot_motor_command_handler_top_defines.svh"

module apmch_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  apmch_pkg::item_t       item,
  input  logic                   low_current_range,
  output apmch_pkg::result_t     result
);

  logic [15:0] status_flags, status_flags_next;
  logic [10:0] command_level, command_level_next;
  logic [7:0]  brake_state, brake_state_next;
  logic [7:0]  brake_enable, brake_enable_next;
  logic [12:0] current_limit, current_limit_next;
  logic [13:0] ctrl_temp_limit, ctrl_temp_limit_next;
  logic [13:0] motor_temp_limit, motor_temp_limit_next;
  logic [15:0] rudder_low, rudder_low_next;
  logic [15:0] rudder_high, rudder_high_next;
  logic [7:0]  slew_fast, slew_fast_next;
  logic [7:0]  slew_slow, slew_slow_next;
  logic [7:0]  clutch_duty, clutch_duty_next;
  logic [apmch_pkg::SLOT_W-1:0] telemetry_slot, telemetry_slot_next;

  logic [15:0]       v;
  logic [15:0]       fault_word;
  logic [15:0]       flags_in;
  logic [15:0]       flags_dec;
  logic [15:0]       flags_tx;
  logic [12:0]       cur_cap;
  apmch_pkg::tlm_t   tlm;
  logic              engaged;
  logic              slot_last;

  assign engaged   = (status_flags & apmch_pkg::FL_ENGAGED) != '0;
  assign slot_last = telemetry_slot == apmch_pkg::SLOT_W'(apmch_pkg::SLOT_COUNT - 1);

  always_comb begin
    v          = {item.byte_two, item.byte_one};
    // overtemp, overcurrent to bits 1..2; port pin .. max rudder to bits 5..9
    fault_word = {6'b0, item.fault_inputs[6:2], 2'b00, item.fault_inputs[1:0], 1'b0};
    flags_in   = status_flags | fault_word | apmch_pkg::FL_SYNC;
    cur_cap    = low_current_range ? apmch_pkg::CUR_CAP_LOW : apmch_pkg::CUR_CAP_HIGH;

    flags_dec             = flags_in;
    command_level_next    = command_level;
    brake_state_next      = brake_state;
    brake_enable_next     = brake_enable;
    current_limit_next    = current_limit;
    ctrl_temp_limit_next  = ctrl_temp_limit;
    motor_temp_limit_next = motor_temp_limit;
    rudder_low_next       = rudder_low;
    rudder_high_next      = rudder_high;
    slew_fast_next        = slew_fast;
    slew_slow_next        = slew_slow;
    clutch_duty_next      = clutch_duty;

    case (item.rx_code)
      apmch_pkg::RX_RESET_OC: begin
        flags_dec = flags_in & ~apmch_pkg::FL_OVERCURRENT;
      end
      apmch_pkg::RX_DRIVE: begin
        if (v > apmch_pkg::CMD_MAX) begin
          // out of range, ignored
        end else if ((flags_in & (apmch_pkg::FL_OVERTEMP | apmch_pkg::FL_OVERCURRENT |
                                  apmch_pkg::FL_BADVOLT)) != '0) begin
          // blocked by a fault
        end else if (((flags_in & (apmch_pkg::FL_PORT_PIN | apmch_pkg::FL_MAX_RUDDER)) != '0)
                     && (v > apmch_pkg::CMD_STOP_V)) begin
          brake_state_next   = '0;
          command_level_next = apmch_pkg::CMD_STOP;
        end else if (((flags_in & (apmch_pkg::FL_STBD_PIN | apmch_pkg::FL_MIN_RUDDER)) != '0)
                     && (v < apmch_pkg::CMD_STOP_V)) begin
          brake_state_next   = '0;
          command_level_next = apmch_pkg::CMD_STOP;
        end else begin
          brake_state_next   = brake_enable;
          command_level_next = v[10:0];
          flags_dec          = flags_in | apmch_pkg::FL_ENGAGED;
        end
      end
      apmch_pkg::RX_MAX_CURRENT: begin
        current_limit_next = (v > 16'(cur_cap)) ? cur_cap : v[12:0];
      end
      apmch_pkg::RX_CTRL_TEMP: begin
        ctrl_temp_limit_next = (v > 16'(apmch_pkg::TEMP_CAP)) ? apmch_pkg::TEMP_CAP : v[13:0];
      end
      apmch_pkg::RX_MOTOR_TEMP: begin
        motor_temp_limit_next = (v > 16'(apmch_pkg::TEMP_CAP)) ? apmch_pkg::TEMP_CAP
                                                               : v[13:0];
      end
      apmch_pkg::RX_RUDDER_MIN: begin
        rudder_low_next = v;
      end
      apmch_pkg::RX_RUDDER_MAX: begin
        rudder_high_next = v;
      end
      apmch_pkg::RX_SLEW: begin
        slew_fast_next = (item.byte_one > apmch_pkg::SLEW_MAX) ? apmch_pkg::SLEW_MAX :
                         (item.byte_one < apmch_pkg::SLEW_MIN) ? apmch_pkg::SLEW_MIN :
                         item.byte_one;
        slew_slow_next = (item.byte_two > apmch_pkg::SLEW_MAX) ? apmch_pkg::SLEW_MAX :
                         (item.byte_two < apmch_pkg::SLEW_MIN) ? apmch_pkg::SLEW_MIN :
                         item.byte_two;
      end
      apmch_pkg::RX_CLUTCH: begin
        clutch_duty_next  = (item.byte_one < apmch_pkg::PWM_MIN)  ? apmch_pkg::PWM_MIN  :
                            (item.byte_one > apmch_pkg::PWM_HIGH) ? apmch_pkg::PWM_FULL :
                            item.byte_one;
        brake_enable_next = item.byte_two;
      end
      default: begin
      end
    endcase

    // telemetry slot, flags packet latches the range flag and drops rebooted
    tlm               = apmch_pkg::tlm_lookup(telemetry_slot);
    flags_tx          = flags_dec | (low_current_range ? 16'h0000 : apmch_pkg::FL_CUR_RANGE);
    status_flags_next = tlm.is_flags ? (flags_tx & ~apmch_pkg::FL_REBOOTED) : flags_dec;

    telemetry_slot_next = slot_last ? '0 : telemetry_slot + 1'b1;

    result.tx_valid           = tlm.valid;
    result.tx_code            = tlm.code;
    result.tx_value           = tlm.is_flags ? flags_tx : tlm.value;
    result.drive_command      = command_level_next;
    result.brake_level        = brake_state_next;
    result.current_ceiling    = current_limit_next;
    result.ctrl_temp_ceiling  = ctrl_temp_limit_next;
    result.motor_temp_ceiling = motor_temp_limit_next;
    result.rudder_low_stop    = rudder_low_next;
    result.rudder_high_stop   = rudder_high_next;
    result.slew_limits        = {slew_slow_next, slew_fast_next};
    result.clutch_level       = clutch_duty_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_flags     <= '0;
      command_level    <= apmch_pkg::CMD_STOP;
      brake_state      <= '0;
      brake_enable     <= '0;
      current_limit    <= '0;
      ctrl_temp_limit  <= '0;
      motor_temp_limit <= '0;
      rudder_low       <= '0;
      rudder_high      <= '0;
      slew_fast        <= '0;
      slew_slow        <= '0;
      clutch_duty      <= apmch_pkg::CLUTCH_RESET;
      telemetry_slot   <= '0;
    end else if (advance) begin
      status_flags     <= status_flags_next;
      command_level    <= command_level_next;
      brake_state      <= brake_state_next;
      brake_enable     <= brake_enable_next;
      current_limit    <= current_limit_next;
      ctrl_temp_limit  <= ctrl_temp_limit_next;
      motor_temp_limit <= motor_temp_limit_next;
      rudder_low       <= rudder_low_next;
      rudder_high      <= rudder_high_next;
      slew_fast        <= slew_fast_next;
      slew_slow        <= slew_slow_next;
      clutch_duty      <= clutch_duty_next;
      telemetry_slot   <= telemetry_slot_next;
    end
  end

  `APMCH_ASSERT_IMP(a_cmd_range, clk, rst, 1'b1, command_level <= 11'(apmch_pkg::CMD_MAX))
  `APMCH_ASSERT_IMP(a_cur_range, clk, rst, 1'b1, current_limit <= apmch_pkg::CUR_CAP_HIGH)
  `APMCH_ASSERT_NXT(a_engaged_sticky, clk, rst, engaged, engaged)
  `APMCH_ASSERT_NXT(a_slot_wrap, clk, rst, advance && slot_last, telemetry_slot == '0)

endmodule

@@ hw/rtl/apmch_out_reg.sv @@
// result register feeding the output stream
module apmch_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  apmch_pkg::result_t  result,
  output logic                m_tvalid,
  input  logic                m_tready,
  output apmch_pkg::result_t  data
);

  logic valid, valid_next;

  always_comb begin
    valid_next = load | (valid & ~m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign m_tvalid = valid;

endmodule
